[rtl/calendar_clock_with_set_mode_core_assert.svh]
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_SET_MODE_CORE_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_SET_MODE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CAL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cal_pkg.sv]
// Types, codes and calendar helper functions for the calendar clock.
`timescale 1ns / 1ps

package cal_pkg;

	localparam logic OpTick = 1'b0;
	localparam logic OpKey  = 1'b1;

	localparam logic [3:0] KeyNext   = 4'd0;
	localparam logic [3:0] KeyUp     = 4'd1;
	localparam logic [3:0] KeyDown   = 4'd2;
	localparam logic [3:0] KeyCancel = 4'd3;

	localparam logic [6:0] SecPerMin  = 7'd60;
	localparam logic [6:0] MinPerHour = 7'd60;
	localparam logic [5:0] HourPerDay = 6'd24;
	localparam logic [4:0] MonthEnd   = 5'd13;
	localparam logic [5:0] SecMax     = 6'd59;
	localparam logic [5:0] MinMax     = 6'd59;
	localparam logic [4:0] HourMax    = 5'd23;
	localparam logic [3:0] MonthMax   = 4'd12;

	localparam logic [3:0] MonthFeb = 4'd2;
	localparam logic [3:0] MonthApr = 4'd4;
	localparam logic [3:0] MonthJun = 4'd6;
	localparam logic [3:0] MonthSep = 4'd9;
	localparam logic [3:0] MonthNov = 4'd11;

	localparam logic [4:0] DaysLeapFeb = 5'd29;
	localparam logic [4:0] DaysFeb     = 5'd28;
	localparam logic [4:0] DaysShort   = 5'd30;
	localparam logic [4:0] DaysLong    = 5'd31;

	// Multiplicative inverse of 25 modulo 2^16 and the largest quotient of
	// a 16-bit multiple of 25; a product at or below it marks a multiple.
	localparam logic [15:0] Inv25    = 16'd23593;
	localparam logic [15:0] MaxMul25 = 16'd2621;

	typedef enum logic [2:0] {
		ModeShow   = 3'd0,
		ModeYear   = 3'd1,
		ModeMonth  = 3'd2,
		ModeDay    = 3'd3,
		ModeHour   = 3'd4,
		ModeMinute = 3'd5,
		ModeSecond = 3'd6
	} mode_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_time_t;

	typedef struct packed {
		mode_t     mode;
		logic      blink;
		cal_time_t run;
		cal_time_t edit;
	} cal_state_t;

	typedef struct packed {
		logic       operation;
		logic [3:0] key_code;
	} cmd_t;

	typedef struct packed {
		logic [15:0] shown_year;
		logic [3:0]  shown_month;
		logic [4:0]  shown_day;
		logic [4:0]  shown_hour;
		logic [5:0]  shown_minute;
		logic [5:0]  shown_second;
		logic [2:0]  mode;
		logic        blank_field;
	} disp_t;

	localparam cal_state_t StateReset = '{
		mode:  ModeShow,
		blink: 1'b0,
		run:   '{year: 16'd1999, month: 4'd12, day: 5'd31,
		         hour: 5'd23, minute: 6'd59, second: 6'd55},
		edit:  '{year: 16'd0, month: 4'd1, day: 5'd1,
		         hour: 5'd0, minute: 6'd0, second: 6'd0}
	};

	// Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
	// Since 400 = 16 * 25, this is a multiple of 4 that is either not a
	// multiple of 25 or a multiple of 16.
	function automatic logic is_leap(input logic [15:0] year);
		logic [15:0] prod;
		logic        mul25;
		prod  = year * Inv25;
		mul25 = (prod <= MaxMul25);
		return (year[1:0] == 2'd0) && (!mul25 || (year[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month,
		input logic [15:0] year);
		logic [4:0] len;
		case (month) inside
			MonthFeb: len = is_leap(year) ? DaysLeapFeb : DaysFeb;
			MonthApr, MonthJun, MonthSep, MonthNov: len = DaysShort;
			default: len = DaysLong;
		endcase
		return len;
	endfunction

endpackage

[rtl/cal_update.sv]
// Next-state and display logic for one tick or key word of the calendar clock.
`timescale 1ns / 1ps

module cal_update (
	input  cal_pkg::cal_state_t st,
	input  cal_pkg::cmd_t       cmd,
	output cal_pkg::cal_state_t st_next,
	output cal_pkg::disp_t      disp
);

	logic                editing;
	logic                editing_next;
	logic                up;
	logic [6:0]          sec_inc;
	logic [6:0]          min_inc;
	logic [5:0]          hour_inc;
	logic [5:0]          day_inc;
	logic [4:0]          month_inc;
	logic [4:0]          run_mlen;
	logic [4:0]          edit_mlen;
	logic [4:0]          day_dec;
	logic [2:0]          m;
	cal_pkg::cal_time_t  run_adv;
	cal_pkg::cal_time_t  edit_adj;

	// Running clock advanced by one second.
	always_comb begin
		run_mlen  = cal_pkg::month_len(st.run.month, st.run.year);
		sec_inc   = {1'b0, st.run.second} + 7'd1;
		min_inc   = {1'b0, st.run.minute} + 7'd1;
		hour_inc  = {1'b0, st.run.hour} + 6'd1;
		day_inc   = {1'b0, st.run.day} + 6'd1;
		month_inc = {1'b0, st.run.month} + 5'd1;
		run_adv   = st.run;
		if (sec_inc < cal_pkg::SecPerMin) begin
			run_adv.second = sec_inc[5:0];
		end else begin
			run_adv.second = '0;
			if (min_inc < cal_pkg::MinPerHour) begin
				run_adv.minute = min_inc[5:0];
			end else begin
				run_adv.minute = '0;
				if (hour_inc < cal_pkg::HourPerDay) begin
					run_adv.hour = hour_inc[4:0];
				end else begin
					run_adv.hour = '0;
					if (day_inc <= {1'b0, run_mlen}) begin
						run_adv.day = day_inc[4:0];
					end else begin
						run_adv.day = 5'd1;
						if (month_inc < cal_pkg::MonthEnd) begin
							run_adv.month = month_inc[3:0];
						end else begin
							run_adv.month = 4'd1;
							run_adv.year  = st.run.year + 16'd1;
						end
					end
				end
			end
		end
	end

	// Edit copy with the field under edit stepped up or down.
	always_comb begin
		up        = (cmd.key_code == cal_pkg::KeyUp);
		edit_mlen = cal_pkg::month_len(st.edit.month, st.edit.year);
		day_dec   = st.edit.day - 5'd1;
		edit_adj  = st.edit;
		unique case (st.mode)
			cal_pkg::ModeYear: begin
				edit_adj.year = up ? st.edit.year + 16'd1 : st.edit.year - 16'd1;
			end
			cal_pkg::ModeMonth: begin
				if (up) begin
					edit_adj.month = (st.edit.month >= cal_pkg::MonthMax) ? 4'd1
						: st.edit.month + 4'd1;
				end else begin
					edit_adj.month = (st.edit.month <= 4'd1) ? cal_pkg::MonthMax
						: st.edit.month - 4'd1;
				end
			end
			cal_pkg::ModeDay: begin
				if (up) begin
					edit_adj.day = (st.edit.day >= edit_mlen) ? 5'd1 : st.edit.day + 5'd1;
				end else if (st.edit.day <= 5'd1) begin
					edit_adj.day = edit_mlen;
				end else begin
					edit_adj.day = (day_dec > edit_mlen) ? edit_mlen : day_dec;
				end
			end
			cal_pkg::ModeHour: begin
				if (up) begin
					edit_adj.hour = (st.edit.hour >= cal_pkg::HourMax) ? 5'd0
						: st.edit.hour + 5'd1;
				end else begin
					edit_adj.hour = (st.edit.hour == 5'd0) ? cal_pkg::HourMax
						: st.edit.hour - 5'd1;
				end
			end
			cal_pkg::ModeMinute: begin
				if (up) begin
					edit_adj.minute = (st.edit.minute >= cal_pkg::MinMax) ? 6'd0
						: st.edit.minute + 6'd1;
				end else begin
					edit_adj.minute = (st.edit.minute == 6'd0) ? cal_pkg::MinMax
						: st.edit.minute - 6'd1;
				end
			end
			cal_pkg::ModeSecond: begin
				if (up) begin
					edit_adj.second = (st.edit.second >= cal_pkg::SecMax) ? 6'd0
						: st.edit.second + 6'd1;
				end else begin
					edit_adj.second = (st.edit.second == 6'd0) ? cal_pkg::SecMax
						: st.edit.second - 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// State update.
	always_comb begin
		editing = (st.mode >= cal_pkg::ModeYear) && (st.mode <= cal_pkg::ModeSecond);
		st_next = st;
		if (cmd.operation == cal_pkg::OpTick) begin
			if (editing) begin
				st_next.blink = ~st.blink;
			end
			st_next.run = run_adv;
			// Fields after the one under edit follow the running clock.
			if ((st.mode >= cal_pkg::ModeYear) && (st.mode <= cal_pkg::ModeMinute)) begin
				if (st.mode <= cal_pkg::ModeYear) begin
					st_next.edit.month = run_adv.month;
				end
				if (st.mode <= cal_pkg::ModeMonth) begin
					st_next.edit.day = run_adv.day;
				end
				if (st.mode <= cal_pkg::ModeDay) begin
					st_next.edit.hour = run_adv.hour;
				end
				if (st.mode <= cal_pkg::ModeHour) begin
					st_next.edit.minute = run_adv.minute;
				end
				st_next.edit.second = run_adv.second;
			end
		end else if (!editing) begin
			if (cmd.key_code == cal_pkg::KeyNext) begin
				st_next.edit = st.run;
				st_next.mode = cal_pkg::ModeYear;
			end
		end else begin
			unique case (cmd.key_code)
				cal_pkg::KeyNext: begin
					if (st.mode == cal_pkg::ModeSecond) begin
						st_next.run  = st.edit;
						st_next.mode = cal_pkg::ModeShow;
					end else begin
						st_next.mode = cal_pkg::mode_t'(3'(st.mode + 3'd1));
					end
				end
				cal_pkg::KeyUp: begin
					st_next.edit = edit_adj;
				end
				cal_pkg::KeyDown: begin
					st_next.edit = edit_adj;
				end
				cal_pkg::KeyCancel: begin
					st_next.mode = cal_pkg::ModeShow;
				end
				default: begin
				end
			endcase
		end
	end

	// Display word from the updated state.
	always_comb begin
		editing_next = (st_next.mode >= cal_pkg::ModeYear)
			&& (st_next.mode <= cal_pkg::ModeSecond);
		m = editing_next ? 3'(st_next.mode) : 3'(cal_pkg::ModeShow);
		disp.shown_year   = (m >= 3'(cal_pkg::ModeYear))   ? st_next.edit.year
			: st_next.run.year;
		disp.shown_month  = (m >= 3'(cal_pkg::ModeMonth))  ? st_next.edit.month
			: st_next.run.month;
		disp.shown_day    = (m >= 3'(cal_pkg::ModeDay))    ? st_next.edit.day
			: st_next.run.day;
		disp.shown_hour   = (m >= 3'(cal_pkg::ModeHour))   ? st_next.edit.hour
			: st_next.run.hour;
		disp.shown_minute = (m >= 3'(cal_pkg::ModeMinute)) ? st_next.edit.minute
			: st_next.run.minute;
		disp.shown_second = (m >= 3'(cal_pkg::ModeSecond)) ? st_next.edit.second
			: st_next.run.second;
		disp.mode         = 3'(st_next.mode);
		disp.blank_field  = editing_next & st_next.blink;
	end

endmodule

[rtl/calendar_clock_with_set_mode_core.sv]
// Top level of the calendar clock with set mode: pipeline registers and state.
`timescale 1ns / 1ps
`include "calendar_clock_with_set_mode_core_assert.svh"

// The cmd channel carries one word per event: a one-second tick or a key
// press with its key code. The disp channel returns exactly one word per
// command word, holding the shown date and time, the current mode and the
// blank flag for the field under edit, all taken after the update.
// Both channels use valid/ready; a word moves on a clock edge where both
// are high.
// A command word is captured into the stage-one register, and the state
// update plus display selection are combinational between that register
// and the output register. The display word is loaded into the output
// register when its command word leaves stage one, and disp_valid rises
// with it. Throughput is one word per cycle while the receiver keeps
// disp_ready high.
// When the receiver stalls, the output register holds its word and stage
// one holds the next command; cmd_ready drops only once both are full.
// The clock state is committed only when a word leaves stage one.
// Reset sets show mode, blink phase low, a running time of 1999-12-31
// 23:59:55 and an edit copy of 0000-01-01 00:00:00, and empties both stages.

module calendar_clock_with_set_mode_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  cal_pkg::cmd_t  cmd,
	output logic           disp_valid,
	input  logic           disp_ready,
	output cal_pkg::disp_t disp
);

	logic                valid_s1;
	cal_pkg::cmd_t       cmd_s1;
	logic                disp_valid_q;
	cal_pkg::disp_t      disp_q;
	cal_pkg::cal_state_t state_q;
	cal_pkg::cal_state_t state_next;
	cal_pkg::disp_t      disp_next;
	logic                advance;

	assign advance    = valid_s1 && (!disp_valid_q || disp_ready);
	assign cmd_ready  = !valid_s1 || advance;
	assign disp_valid = disp_valid_q;
	assign disp       = disp_q;

	cal_update u_update (
		.st      (state_q),
		.cmd     (cmd_s1),
		.st_next (state_next),
		.disp    (disp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			disp_valid_q <= 1'b0;
			state_q      <= cal_pkg::StateReset;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				disp_valid_q <= 1'b1;
				state_q      <= state_next;
			end else if (disp_ready) begin
				disp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			disp_q <= disp_next;
		end
	end

	`CAL_ASSERT_NEXT(a_accept_fills_s1, cmd_valid && cmd_ready, valid_s1,
		"Accepted command word did not reach stage one.")
	`CAL_ASSERT_NEXT(a_advance_fills_out, advance, disp_valid_q,
		"Stage one advanced but no display word was registered.")
	`CAL_ASSERT_NEXT(a_state_holds, !advance, $stable(state_q),
		"Clock state changed without a word leaving stage one.")
	`CAL_ASSERT_NOW(a_run_in_range, 1'b1,
		(state_q.run.second <= cal_pkg::SecMax) && (state_q.run.minute <= cal_pkg::MinMax)
		&& (state_q.run.hour <= cal_pkg::HourMax),
		"Running time field out of range.")

endmodule
